[rtl/core/nnsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsr_pkg
// Shared constants and controller/datapath interface types of the
// nearest-neighbor stereo resampler.
// ----------------------------------------------------------------------------
package nnsr_pkg;

  localparam int unsigned PHASE_FRAC_BITS = 16;
  localparam int unsigned MAX_RUN         = 64;

  localparam int unsigned PHASE_W  = 40;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_SOURCE  = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 24'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new input item
    logic advance;     // emit one output frame: bump counters and phase
    logic present;     // load the output register
    logic run_last;    // flag values for the output register
    logic sound_done;
    logic finish;      // close the item: reset or bump the input index
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;        // another output frame belongs to this item
    logic end_cond;    // end of sound or output count reached
  } dp_status_t;

endpackage

[rtl/core/nnsr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsr_dp
// Datapath: configuration registers, phase accumulator, frame counters,
// latched input item and the output register.
// ----------------------------------------------------------------------------
module nnsr_dp #(
  parameter int unsigned PhaseFracBits = nnsr_pkg::PHASE_FRAC_BITS,
  parameter int unsigned MaxRun        = nnsr_pkg::MAX_RUN
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nnsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nnsr_pkg::COUNT_W-1:0]        cfg_data_i,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                eos_i,
  input  nnsr_pkg::dp_cmd_t                   cmd_i,
  output nnsr_pkg::dp_status_t                status_o,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                out_last_o,
  output logic                                out_done_o
);

  localparam int unsigned PhaseW = nnsr_pkg::PHASE_W;
  localparam int unsigned IdxW   = nnsr_pkg::COUNT_W;
  localparam int unsigned IntW   = PhaseW - PhaseFracBits;
  localparam int unsigned CmpW   = (IntW > IdxW) ? IntW : IdxW;
  localparam int unsigned RunW   = $clog2(MaxRun + 1);

  logic [nnsr_pkg::STEP_W-1:0]  step_q;
  logic [nnsr_pkg::COUNT_W-1:0] count_q;
  logic                         mono_q;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [IdxW-1:0]   ifi_q, ifi_d;
  logic [IdxW-1:0]   ofi_q, ofi_d;
  logic [RunW-1:0]   run_q, run_d;

  logic signed [nnsr_pkg::SAMPLE_W-1:0] left_q, right_q;
  logic                                 eos_q;

  logic [PhaseW:0]   phase_sum;
  logic [CmpW-1:0]   pos_int;
  logic [CmpW-1:0]   ifi_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= nnsr_pkg::STEP_RESET;
      count_q <= nnsr_pkg::COUNT_RESET;
      mono_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nnsr_pkg::CFG_SOURCE_STEP:  step_q  <= cfg_data_i[nnsr_pkg::STEP_W-1:0];
        nnsr_pkg::CFG_OUTPUT_COUNT: count_q <= cfg_data_i;
        nnsr_pkg::CFG_MONO_SOURCE:  mono_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign phase_sum = {1'b0, phase_q} + (PhaseW+1)'(step_q);
  assign pos_int   = CmpW'(phase_q[PhaseW-1:PhaseFracBits]);
  assign ifi_ext   = CmpW'(ifi_q);

  assign status_o.end_cond = eos_q || (ofi_q >= count_q);
  assign status_o.more     = (run_q < RunW'(MaxRun)) && (ofi_q < count_q) &&
                             (eos_q || (pos_int <= ifi_ext));

  always_comb begin
    phase_d = phase_q;
    ifi_d   = ifi_q;
    ofi_d   = ofi_q;
    run_d   = run_q;
    if (cmd_i.load) begin
      run_d = '0;
    end
    if (cmd_i.advance) begin
      ofi_d   = ofi_q + 1'b1;
      run_d   = run_q + 1'b1;
      // The phase saturates instead of wrapping.
      phase_d = phase_sum[PhaseW] ? {PhaseW{1'b1}} : phase_sum[PhaseW-1:0];
    end
    if (cmd_i.finish) begin
      if (eos_q) begin
        phase_d = '0;
        ifi_d   = '0;
        ofi_d   = '0;
      end else if (ifi_q != {IdxW{1'b1}}) begin
        ifi_d = ifi_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      ifi_q   <= '0;
      ofi_q   <= '0;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ifi_q   <= ifi_d;
      ofi_q   <= ofi_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= left_i;
      right_q <= mono_q ? left_i : right_i;
      eos_q   <= eos_i;
    end
    if (cmd_i.present) begin
      out_left_o  <= left_q;
      out_right_o <= right_q;
      out_last_o  <= cmd_i.run_last;
      out_done_o  <= cmd_i.sound_done;
    end
  end

endmodule

[rtl/core/nnsr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnsr_ctrl
// Controller: accepts an item, steps the datapath once per output frame and
// drives the output handshake.
// ----------------------------------------------------------------------------
module nnsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  nnsr_pkg::dp_status_t status_i,
  output nnsr_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   pending_q;   // a frame has been counted but not yet presented
  logic   last_q;      // the presented frame closes the run
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.finish     = (state_q == ST_FINISH);
    if (state_q == ST_CHECK) begin
      cmd_o.advance    = status_i.more;
      cmd_o.present    = pending_q;
      cmd_o.run_last   = !status_i.more;
      cmd_o.sound_done = !status_i.more && status_i.end_cond;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pending_q <= 1'b0;
            state_q   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          pending_q <= status_i.more;
          if (pending_q) begin
            out_valid_q <= 1'b1;
            last_q      <= !status_i.more;
            state_q     <= ST_WAIT;
          end else if (!status_i.more) begin
            state_q <= ST_FINISH;
          end
        end
        ST_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= last_q ? ST_FINISH : ST_CHECK;
          end
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_out_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q)
    else $error("output valid while accepting input");

  a_wait_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) == out_valid_q)
    else $error("output valid out of step with wait state");

  a_present_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.present |-> !out_valid_q)
    else $error("output register overwritten before accept");

  a_advance_needs_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> status_i.more && (state_q == ST_CHECK))
    else $error("frame counted without a pending output");

  a_last_leads_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && out_ready_i && last_q) |=> (state_q == ST_FINISH))
    else $error("run did not close after its last frame");

endmodule

[rtl/core/nearest_neighbor_stereo_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_stereo_resampler
// An item runs through idle, check, then a check and a wait per output frame
// (the output side can stall it in wait) and finally finish. The first frame
// is counted in the first check and presented in the second. Each frame costs
// one phase-accumulator step plus an output handshake. Reset clears the phase
// and frame counters and loads step 1.0, output count 1, stereo mode.
// ----------------------------------------------------------------------------
module nearest_neighbor_stereo_resampler #(
  parameter int unsigned PhaseFracBits = nnsr_pkg::PHASE_FRAC_BITS,
  parameter int unsigned MaxRun        = nnsr_pkg::MAX_RUN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nnsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnsr_pkg::COUNT_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // left_sample, right_sample
  input  logic                            s_axis_tlast,  // end_of_sound
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // out_left, out_right
  output logic                            m_axis_tlast,  // run_last
  output logic                            m_axis_tuser   // sound_done
);

  nnsr_pkg::dp_cmd_t    cmd;
  nnsr_pkg::dp_status_t status;

  logic signed [nnsr_pkg::SAMPLE_W-1:0] out_left, out_right;

  nnsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nnsr_dp #(
    .PhaseFracBits (PhaseFracBits),
    .MaxRun        (MaxRun)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .left_i      (s_axis_tdata[15:0]),
    .right_i     (s_axis_tdata[31:16]),
    .eos_i       (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_left_o  (out_left),
    .out_right_o (out_right),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_right, out_left};

endmodule

[tb/sv/nearest_neighbor_stereo_resampler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_stereo_resampler_tb
// Sends sounds of source frames through the resampler and checks every output
// frame against a floor-resampling predictor with its own phase accumulator.
// A short table of corner cases comes first, then random sounds with random
// rates and output counts, under changing idle patterns on both streams.
// ----------------------------------------------------------------------------
module nearest_neighbor_stereo_resampler_tb;

  localparam int unsigned SAMPLE_W        = nnsr_pkg::SAMPLE_W;
  localparam int unsigned STEP_W          = nnsr_pkg::STEP_W;
  localparam int unsigned COUNT_W         = nnsr_pkg::COUNT_W;
  localparam int unsigned PHASE_W         = nnsr_pkg::PHASE_W;
  localparam int unsigned CFG_IDX_W       = nnsr_pkg::CFG_IDX_W;
  localparam int unsigned PHASE_FRAC_BITS = nnsr_pkg::PHASE_FRAC_BITS;
  localparam int unsigned MAX_RUN         = nnsr_pkg::MAX_RUN;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned NUM_ROWS      = 29;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                run_last;
    logic                sound_done;
  } out_frame_t;

  typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_ONE} want_e;

  typedef struct {
    row_kind_e           kind;
    want_e               want;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                eos;
    logic [STEP_W-1:0]   step;
    logic [COUNT_W-1:0]  count;
    logic                mono;
    out_frame_t          result;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = nnsr_pkg::CFG_SOURCE_STEP;
  logic [COUNT_W-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;  // left_sample, right_sample
  logic                 s_axis_tlast  = 1'b0;  // end_of_sound
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;  // out_left, out_right
  logic                 m_axis_tlast;  // run_last
  logic                 m_axis_tuser;  // sound_done

  // Predictor copy of the registers and of the resampling state.
  logic [STEP_W-1:0]  cur_step;
  logic [COUNT_W-1:0] cur_count;
  logic               cur_mono;
  logic [PHASE_W-1:0] phase_acc;
  logic [COUNT_W-1:0] src_index;
  logic [COUNT_W-1:0] emitted;

  out_frame_t  expected_frames[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  nearest_neighbor_stereo_resampler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Emits every output frame whose source position lies on this frame; on the
  // end of the sound the frame repeats until the output count is met.
  function automatic void resample_frame(input logic [SAMPLE_W-1:0] left,
                                         input logic [SAMPLE_W-1:0] right,
                                         input logic eos, input bit keep);
    out_frame_t       run[$];
    out_frame_t       frame;
    logic [PHASE_W:0] sum;
    frame.left       = left;
    frame.right      = cur_mono ? left : right;
    frame.run_last   = 1'b0;
    frame.sound_done = 1'b0;
    while (run.size() < MAX_RUN && emitted < cur_count) begin
      if (!eos && (phase_acc >> PHASE_FRAC_BITS) > src_index) break;
      run.push_back(frame);
      emitted = emitted + 1'b1;
      sum = {1'b0, phase_acc} + cur_step;
      phase_acc = sum[PHASE_W] ? {PHASE_W{1'b1}} : sum[PHASE_W-1:0];
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_last = 1'b1;
      run[run.size()-1].sound_done = eos || (emitted >= cur_count);
    end
    if (keep) begin
      foreach (run[i]) expected_frames.push_back(run[i]);
    end
    if (eos) begin
      phase_acc = '0;
      src_index = '0;
      emitted   = '0;
    end else if (src_index != {COUNT_W{1'b1}}) begin
      src_index = src_index + 1'b1;
    end
  endfunction

  task automatic send_frame(input logic [SAMPLE_W-1:0] left,
                            input logic [SAMPLE_W-1:0] right,
                            input logic eos, input bit keep);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    resample_frame(left, right, eos, keep);
  endtask

  // Holds the input side until all predicted output frames have been taken.
  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_frames.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [STEP_W-1:0] step,
                              input logic [COUNT_W-1:0] count, input logic mono);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= nnsr_pkg::CFG_SOURCE_STEP;
    cfg_data_i <= step;
    @(posedge clk_i);
    cur_step   = step;
    cfg_idx_i  <= nnsr_pkg::CFG_OUTPUT_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    cur_count  = count;
    cfg_idx_i  <= nnsr_pkg::CFG_MONO_SOURCE;
    cfg_data_i <= COUNT_W'(mono);
    @(posedge clk_i);
    cur_mono   = mono;
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: random stalls, and each taken frame is checked in order.
  always @(posedge clk_i) begin
    out_frame_t got;
    out_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left       = m_axis_tdata[15:0];
      got.right      = m_axis_tdata[31:16];
      got.run_last   = m_axis_tlast;
      got.sound_done = m_axis_tuser;
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected output frame %h", got));
      end else begin
        want = expected_frames.pop_front();
        if (got.left != want.left)
          report_mismatch($sformatf("out_left %h, expected %h", got.left, want.left));
        if (got.right != want.right)
          report_mismatch($sformatf("out_right %h, expected %h", got.right, want.right));
        if (got.run_last != want.run_last)
          report_mismatch($sformatf("run_last %b, expected %b",
                                    got.run_last, want.run_last));
        if (got.sound_done != want.sound_done)
          report_mismatch($sformatf("sound_done %b, expected %b",
                                    got.sound_done, want.sound_done));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   directed_rows [NUM_ROWS];
    int unsigned items_sent;
    int unsigned frames;
    int unsigned pick;
    longint      step;
    longint      nominal;
    longint      count;

    directed_rows = '{
      // Defaults after reset: one output, then the count is already met.
      '{ROW_FRAME,  WANT_ONE,   16'h7FFF, 16'h8000, 1'b0, 24'h0, 24'h0, 1'b0,
        '{16'h7FFF, 16'h8000, 1'b1, 1'b1}},
      '{ROW_FRAME,  WANT_NONE,  16'h0001, 16'h0002, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_NONE,  16'h8000, 16'h7FFF, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Mono, upsampling by two.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h008000, 24'd3, 1'b1, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h1234, 16'h5678, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'hFFFF, 16'h0000, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h0000, 16'hFFFF, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Zero step: every frame hits the run cap, including the final one.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h000000, 24'd200, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h5555, 16'hAAAA, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'hAAAA, 16'h5555, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h7FFF, 16'h8000, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Largest step: frames in between emit nothing, the last one repeats.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'hFFFFFF, 24'd2, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h0F0F, 16'hF0F0, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h0100, 16'h0200, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h0300, 16'h0400, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h8001, 16'h7FFE, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Smallest legal step with the largest count.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h000400, 24'hFFFFFF, 1'b1, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'hC000, 16'h3FFF, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h4000, 16'hBFFF, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Zero output count: nothing ever comes out.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h010000, 24'd0, 1'b0, '0},
      '{ROW_FRAME,  WANT_NONE,  16'h7FFF, 16'h7FFF, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_NONE,  16'h8000, 16'h8000, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Unit step, early end of sound: the final frame fills up the count.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h010000, 24'd5, 1'b0, '0},
      '{ROW_FRAME,  WANT_ONE,   16'h0042, 16'hFFBE, 1'b0, 24'h0, 24'h0, 1'b0,
        '{16'h0042, 16'hFFBE, 1'b1, 1'b0}},
      '{ROW_FRAME,  WANT_MODEL, 16'h1111, 16'hEEEE, 1'b1, 24'h0, 24'h0, 1'b0, '0},
      // Downsampling by 1.5.
      '{ROW_CONFIG, WANT_MODEL, 16'h0, 16'h0, 1'b0, 24'h018000, 24'd4, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h2222, 16'hDDDD, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h3333, 16'hCCCC, 1'b0, 24'h0, 24'h0, 1'b0, '0},
      '{ROW_FRAME,  WANT_MODEL, 16'h6666, 16'h9999, 1'b1, 24'h0, 24'h0, 1'b0, '0}
    };

    mismatches    = 0;
    send_idle_pct = 8;
    recv_idle_pct = 88;
    cur_step      = nnsr_pkg::STEP_RESET;
    cur_count     = nnsr_pkg::COUNT_RESET;
    cur_mono      = 1'b0;
    phase_acc     = '0;
    src_index     = '0;
    emitted       = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain(SETTLE_CYCLES);
        program_regs(directed_rows[i].step, directed_rows[i].count, directed_rows[i].mono);
      end else begin
        send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].eos,
                   directed_rows[i].want == WANT_MODEL);
        if (directed_rows[i].want == WANT_ONE) expected_frames.push_back(directed_rows[i].result);
      end
    end

    // Random sounds: the output count mostly matches the rate, sometimes not.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 88;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      frames = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      pick = $urandom_range(0, 19);
      if (pick == 0)
        step = $urandom_range(1024, 16383);
      else if (pick == 1)
        step = $urandom_range(262145, 24'hFFFFFF);
      else
        step = $urandom_range(16384, 262144);
      nominal = (longint'(frames) * 65536 + step / 2) / step;
      if ($urandom_range(0, 4) == 0)
        count = $urandom_range(0, 32'(2 * nominal + 3));
      else
        count = nominal + longint'($urandom_range(0, 4)) - 2;
      if (count < 0) count = 0;
      drain(SETTLE_CYCLES);
      program_regs(STEP_W'(step), COUNT_W'(count), 1'($urandom_range(0, 1)));
      for (int unsigned f = 0; f < frames; f++) begin
        if ($urandom_range(0, 29) == 0) drain(0);
        send_frame(pick_sample(), pick_sample(), f == frames - 1, 1'b1);
        items_sent++;
      end
    end

    drain(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
